/* rtl/core/gwf_pkg.sv */
// ----------------------------------------------------------------------------
// gwf_pkg
// Shared types, codes and constants of the grid wall follower.
// ----------------------------------------------------------------------------
package gwf_pkg;

  localparam int unsigned COL_W    = 6;
  localparam int unsigned ROW_W    = 6;
  localparam int unsigned LIM_W    = 7;
  localparam int unsigned ADDR_W   = COL_W + ROW_W;
  localparam int unsigned CELLS    = 1 << ADDR_W;
  localparam int unsigned MAX_COLS = 1 << COL_W;
  localparam int unsigned MAX_ROWS = 1 << ROW_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  // Cell flag bits
  localparam int unsigned FLAG_WALL_BIT    = 0;
  localparam int unsigned FLAG_VISITED_BIT = 1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_S = 2'd1,
    DIR_E = 2'd2,
    DIR_W = 2'd3
  } dir_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLUMNS = 3'd0,
    CFG_GRID_ROWS    = 3'd1,
    CFG_ENTRY_X      = 3'd2,
    CFG_ENTRY_Y      = 3'd3,
    CFG_EXIT_X       = 3'd4,
    CFG_EXIT_Y       = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [COL_W-1:0] cell_col;
    logic [ROW_W-1:0] cell_row;
    logic             cell_is_wall;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] pos_col;
    logic [ROW_W-1:0] pos_row;
    logic [1:0]       heading;
    logic             moved;
    logic             reached_exit;
    logic             read_wall;
    logic             read_visited;
  } out_item_t;

  typedef struct packed {
    logic [LIM_W-1:0] grid_columns;
    logic [LIM_W-1:0] grid_rows;
    logic [COL_W-1:0] entry_x;
    logic [ROW_W-1:0] entry_y;
    logic [COL_W-1:0] exit_x;
    logic [ROW_W-1:0] exit_y;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        wdata;
  } mem_req_t;

  // Neighbor k (0 first) tried for a given heading.
  function automatic dir_e try_dir(dir_e facing, logic [1:0] k);
    logic [7:0] ord;
    case (facing)
      DIR_N:   ord = {DIR_S, DIR_W, DIR_N, DIR_E};
      DIR_S:   ord = {DIR_N, DIR_E, DIR_S, DIR_W};
      DIR_E:   ord = {DIR_W, DIR_N, DIR_E, DIR_S};
      default: ord = {DIR_E, DIR_S, DIR_W, DIR_N};
    endcase
    return dir_e'(ord[{k, 1'b0} +: 2]);
  endfunction

endpackage

/* rtl/core/gwf_cell_mem.sv */
// ----------------------------------------------------------------------------
// gwf_cell_mem
// Single-port cell flag memory with registered read data.
// ----------------------------------------------------------------------------
module gwf_cell_mem (
  input  logic              clk_i,
  input  gwf_pkg::mem_req_t req_i,
  output logic [1:0]        rdata_o
);

  logic [1:0] mem_q [gwf_pkg::CELLS];
  logic [1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem_q[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem_q[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/gwf_walker.sv */
// ----------------------------------------------------------------------------
// gwf_walker
// Command sequencer: clears the cell memory, runs load, start, step and read.
// ----------------------------------------------------------------------------
module gwf_walker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gwf_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gwf_pkg::in_item_t  in_data_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output gwf_pkg::out_item_t res_o,
  output gwf_pkg::mem_req_t  mem_req_o,
  input  logic [1:0]         mem_rdata_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_RD_WAIT,
    ST_EMIT
  } state_e;

  state_e                        state_q, state_d;
  logic [gwf_pkg::ADDR_W-1:0]    clr_cnt_q, clr_cnt_d;
  logic [gwf_pkg::COL_W-1:0]     col_q, col_d;
  logic [gwf_pkg::ROW_W-1:0]     row_q, row_d;
  gwf_pkg::dir_e                 facing_q, facing_d;
  logic                          done_q, done_d;
  logic [1:0]                    k_q, k_d;
  logic [gwf_pkg::COL_W-1:0]     cand_col_q, cand_col_d;
  logic [gwf_pkg::ROW_W-1:0]     cand_row_q, cand_row_d;
  gwf_pkg::dir_e                 cand_dir_q, cand_dir_d;
  logic                          moved_q, moved_d;
  logic                          rd_wall_q, rd_wall_d;
  logic                          rd_vis_q, rd_vis_d;

  logic [gwf_pkg::LIM_W-1:0]     lim_c, lim_r;
  gwf_pkg::dir_e                 dir;
  logic [gwf_pkg::LIM_W-1:0]     nc, nr;
  logic                          edge_ok, in_grid;
  logic                          accept;

  // Clamp the grid size to the store.
  assign lim_c = (cfg_i.grid_columns > gwf_pkg::LIM_W'(gwf_pkg::MAX_COLS))
                 ? gwf_pkg::LIM_W'(gwf_pkg::MAX_COLS) : cfg_i.grid_columns;
  assign lim_r = (cfg_i.grid_rows > gwf_pkg::LIM_W'(gwf_pkg::MAX_ROWS))
                 ? gwf_pkg::LIM_W'(gwf_pkg::MAX_ROWS) : cfg_i.grid_rows;

  // Candidate neighbor for the current try.
  always_comb begin
    dir     = gwf_pkg::try_dir(facing_q, k_q);
    nc      = {1'b0, col_q};
    nr      = {1'b0, row_q};
    edge_ok = 1'b1;
    case (dir)
      gwf_pkg::DIR_N: begin
        edge_ok = (row_q != '0);
        nr      = {1'b0, row_q} - 1'b1;
      end
      gwf_pkg::DIR_S: nr = {1'b0, row_q} + 1'b1;
      gwf_pkg::DIR_E: nc = {1'b0, col_q} + 1'b1;
      default: begin
        edge_ok = (col_q != '0);
        nc      = {1'b0, col_q} - 1'b1;
      end
    endcase
    in_grid = edge_ok && (nc < lim_c) && (nr < lim_r);
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    col_d      = col_q;
    row_d      = row_q;
    facing_d   = facing_q;
    done_d     = done_q;
    k_d        = k_q;
    cand_col_d = cand_col_q;
    cand_row_d = cand_row_q;
    cand_dir_d = cand_dir_q;
    moved_d    = moved_q;
    rd_wall_d  = rd_wall_q;
    rd_vis_d   = rd_vis_q;
    mem_req_o  = '0;

    case (state_q)
      ST_CLEAR: begin
        mem_req_o.en   = 1'b1;
        mem_req_o.we   = 1'b1;
        mem_req_o.addr = clr_cnt_q;
        clr_cnt_d      = clr_cnt_q + 1'b1;
        if (clr_cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          moved_d   = 1'b0;
          rd_wall_d = 1'b0;
          rd_vis_d  = 1'b0;
          k_d       = '0;
          case (in_data_i.cmd)
            gwf_pkg::CMD_LOAD: begin
              mem_req_o.en   = 1'b1;
              mem_req_o.we   = 1'b1;
              mem_req_o.addr = {in_data_i.cell_row, in_data_i.cell_col};
              mem_req_o.wdata[gwf_pkg::FLAG_WALL_BIT] = in_data_i.cell_is_wall;
              state_d = ST_EMIT;
            end
            gwf_pkg::CMD_START: begin
              col_d    = cfg_i.entry_x;
              row_d    = cfg_i.entry_y;
              facing_d = gwf_pkg::DIR_E;
              done_d   = 1'b0;
              state_d  = ST_EMIT;
            end
            gwf_pkg::CMD_STEP: state_d = ST_PROBE;
            default: begin
              mem_req_o.en   = 1'b1;
              mem_req_o.addr = {in_data_i.cell_row, in_data_i.cell_col};
              state_d        = ST_RD_WAIT;
            end
          endcase
        end
      end
      ST_PROBE: begin
        if (in_grid) begin
          mem_req_o.en   = 1'b1;
          mem_req_o.addr = {nr[gwf_pkg::ROW_W-1:0], nc[gwf_pkg::COL_W-1:0]};
          cand_col_d     = nc[gwf_pkg::COL_W-1:0];
          cand_row_d     = nr[gwf_pkg::ROW_W-1:0];
          cand_dir_d     = dir;
          state_d        = ST_CHECK;
        end else if (k_q == 2'd3) begin
          facing_d = gwf_pkg::DIR_W;
          done_d   = done_q || (col_q == cfg_i.exit_x && row_q == cfg_i.exit_y);
          state_d  = ST_EMIT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_CHECK: begin
        if (!mem_rdata_i[gwf_pkg::FLAG_WALL_BIT]) begin
          // Free cell: wall bit is known clear, so write visited alone.
          mem_req_o.en   = 1'b1;
          mem_req_o.we   = 1'b1;
          mem_req_o.addr = {cand_row_q, cand_col_q};
          mem_req_o.wdata[gwf_pkg::FLAG_VISITED_BIT] = 1'b1;
          col_d    = cand_col_q;
          row_d    = cand_row_q;
          facing_d = cand_dir_q;
          moved_d  = 1'b1;
          done_d   = done_q || (cand_col_q == cfg_i.exit_x && cand_row_q == cfg_i.exit_y);
          state_d  = ST_EMIT;
        end else if (k_q == 2'd3) begin
          facing_d = gwf_pkg::DIR_W;
          done_d   = done_q || (col_q == cfg_i.exit_x && row_q == cfg_i.exit_y);
          state_d  = ST_EMIT;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_PROBE;
        end
      end
      ST_RD_WAIT: begin
        rd_wall_d = mem_rdata_i[gwf_pkg::FLAG_WALL_BIT];
        rd_vis_d  = mem_rdata_i[gwf_pkg::FLAG_VISITED_BIT];
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      col_q     <= '0;
      row_q     <= '0;
      facing_q  <= gwf_pkg::DIR_E;
      done_q    <= 1'b0;
      k_q       <= '0;
      moved_q   <= 1'b0;
      rd_wall_q <= 1'b0;
      rd_vis_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      col_q     <= col_d;
      row_q     <= row_d;
      facing_q  <= facing_d;
      done_q    <= done_d;
      k_q       <= k_d;
      moved_q   <= moved_d;
      rd_wall_q <= rd_wall_d;
      rd_vis_q  <= rd_vis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_col_q <= cand_col_d;
    cand_row_q <= cand_row_d;
    cand_dir_q <= cand_dir_d;
  end

  assign res_valid_o        = (state_q == ST_EMIT);
  assign res_o.pos_col      = col_q;
  assign res_o.pos_row      = row_q;
  assign res_o.heading      = facing_q;
  assign res_o.moved        = moved_q;
  assign res_o.reached_exit = done_q;
  assign res_o.read_wall    = rd_wall_q;
  assign res_o.read_visited = rd_vis_q;

endmodule

/* rtl/core/grid_wall_follower.sv */
// ----------------------------------------------------------------------------
// grid_wall_follower
// Right-hand-rule maze walker over a 64 x 64 cell flag memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one command
//   per transfer: load a wall flag, start at the entry, take one step, or
//   read a cell. Each command yields exactly one result transfer on the
//   output channel (out_valid_o / out_stall_i / out_data_o).
//   Configuration (grid size, entry, exit) is written through cfg_we_i,
//   cfg_idx_i and cfg_wdata_i; the user must write it only while no
//   command is in flight, as the block does not enforce this. A step
//   makes up to four neighbor reads of the single-port cell memory, each
//   followed by a check state; the check that finds a free cell also
//   carries the visited write.
//   One command is in flight at a time; the next is taken once the result
//   sits in the output register, even if the receiver has not taken it yet.
//   Reset: the walker goes to (0,0) facing east and the cell memory is
//   cleared by a sweep over all 4096 cells, one cell a cycle, during which
//   in_stall_o is high; configuration writes are taken as ever.
//   When the receiver stalls, the result holds in the output register and
//   the sequencer waits with the next result until the register frees.
// ----------------------------------------------------------------------------
module grid_wall_follower (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gwf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gwf_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  gwf_pkg::in_item_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output gwf_pkg::out_item_t                 out_data_o
);

  gwf_pkg::cfg_t      cfg_q;
  gwf_pkg::mem_req_t  mem_req;
  logic [1:0]         mem_rdata;
  logic               res_valid;
  logic               res_ready;
  gwf_pkg::out_item_t res;
  logic               out_valid_q;
  gwf_pkg::out_item_t out_q;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_columns <= gwf_pkg::LIM_W'(gwf_pkg::MAX_COLS);
      cfg_q.grid_rows    <= gwf_pkg::LIM_W'(gwf_pkg::MAX_ROWS);
      cfg_q.entry_x      <= '0;
      cfg_q.entry_y      <= '0;
      cfg_q.exit_x       <= '0;
      cfg_q.exit_y       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gwf_pkg::CFG_GRID_COLUMNS: cfg_q.grid_columns <= cfg_wdata_i;
        gwf_pkg::CFG_GRID_ROWS:    cfg_q.grid_rows    <= cfg_wdata_i;
        gwf_pkg::CFG_ENTRY_X:      cfg_q.entry_x <= cfg_wdata_i[gwf_pkg::COL_W-1:0];
        gwf_pkg::CFG_ENTRY_Y:      cfg_q.entry_y <= cfg_wdata_i[gwf_pkg::ROW_W-1:0];
        gwf_pkg::CFG_EXIT_X:       cfg_q.exit_x  <= cfg_wdata_i[gwf_pkg::COL_W-1:0];
        gwf_pkg::CFG_EXIT_Y:       cfg_q.exit_y  <= cfg_wdata_i[gwf_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  gwf_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  gwf_cell_mem u_cell_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output register: free when empty or being taken this cycle.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload advances only on a new result.
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sim/tb_grid_wall_follower.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_wall_follower
// Self-checking bench for the right-hand-rule maze walker. A scoreboard
// class mirrors the cell flags, walker position, heading and exit flag and
// predicts every result. Stimulus runs a short directed part, then random
// mazes loaded cell by cell and walked step by step, under changing grid
// settings and changing idle and stall pressure on both channels.
// ----------------------------------------------------------------------------
module tb_grid_wall_follower;
  import gwf_pkg::*;

  localparam int HOLD_CYCLES = 300;  // long receiver hold-off to fill the block
  localparam int MAX_REPORTS = 40;   // cap on printed mismatch lines
  localparam int ITEM_TARGET = 540;  // stop point; the last walk phase runs a bit past it

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the walker and the cell flags, queues one expected
  // result per accepted command and checks results in order.
  // --------------------------------------------------------------------------
  class walk_tracker;
    logic [1:0]       cells [CELLS];
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    dir_e             facing;
    logic             done;
    cfg_t             regs;
    out_item_t        due [$];
    int               errors;

    function new();
      foreach (cells[i]) cells[i] = 2'b00;
      col    = '0;
      row    = '0;
      facing = DIR_E;
      done   = 1'b0;
      regs   = '0;
      regs.grid_columns = LIM_W'(MAX_COLS);
      regs.grid_rows    = LIM_W'(MAX_ROWS);
      errors = 0;
    endfunction

    // Clip a size register to the store size.
    static function int span(logic [LIM_W-1:0] r, int cap);
      return (int'(r) > cap) ? cap : int'(r);
    endfunction

    // Neighbor tried k-th for a heading: right hand first, then ahead,
    // then left, then back.
    function dir_e probe_dir(dir_e f, int k);
      dir_e seq [4];
      case (f)
        DIR_N:   seq = '{DIR_E, DIR_N, DIR_W, DIR_S};
        DIR_S:   seq = '{DIR_W, DIR_S, DIR_E, DIR_N};
        DIR_E:   seq = '{DIR_S, DIR_E, DIR_N, DIR_W};
        default: seq = '{DIR_N, DIR_W, DIR_S, DIR_E};
      endcase
      return seq[k];
    endfunction

    // A neighbor is open when it is inside the grid and not a wall.
    function bit open_cell(dir_e d, output int nc, output int nr);
      int c;
      int r;
      c  = int'(col);
      r  = int'(row);
      nc = 0;
      nr = 0;
      case (d)
        DIR_N: begin
          if (r == 0) return 1'b0;
          r--;
        end
        DIR_S: r++;
        DIR_E: c++;
        default: begin
          if (c == 0) return 1'b0;
          c--;
        end
      endcase
      if (c >= span(regs.grid_columns, MAX_COLS) || r >= span(regs.grid_rows, MAX_ROWS))
        return 1'b0;
      if (cells[r * MAX_COLS + c][FLAG_WALL_BIT]) return 1'b0;
      nc = c;
      nr = r;
      return 1'b1;
    endfunction

    function void note_input(in_item_t it);
      out_item_t e;
      int        slot;
      int        nc;
      int        nr;
      slot = int'(it.cell_row) * MAX_COLS + int'(it.cell_col);
      e    = '0;
      case (it.cmd)
        CMD_LOAD: begin
          // Load rewrites the wall flag and drops the visited flag.
          cells[slot] = 2'b00;
          cells[slot][FLAG_WALL_BIT] = it.cell_is_wall;
        end
        CMD_START: begin
          col    = regs.entry_x;
          row    = regs.entry_y;
          facing = DIR_E;
          done   = 1'b0;
        end
        CMD_STEP: begin
          for (int k = 0; k < 4 && !e.moved; k++) begin
            dir_e d;
            d = probe_dir(facing, k);
            if (open_cell(d, nc, nr)) begin
              col    = COL_W'(nc);
              row    = ROW_W'(nr);
              cells[nr * MAX_COLS + nc][FLAG_VISITED_BIT] = 1'b1;
              facing = d;
              e.moved = 1'b1;
            end
          end
          // Boxed in: stay put and turn west.
          if (!e.moved) facing = DIR_W;
          if (col == regs.exit_x && row == regs.exit_y) done = 1'b1;
        end
        default: begin
          e.read_wall    = cells[slot][FLAG_WALL_BIT];
          e.read_visited = cells[slot][FLAG_VISITED_BIT];
        end
      endcase
      e.pos_col      = col;
      e.pos_row      = row;
      e.heading      = facing;
      e.reached_exit = done;
      due.push_back(e);
    endfunction

    function void report(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t: %s", $time, what);
    endfunction

    function void match(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want)
        report($sformatf("%s mismatch: expected %0h, actual %0h", name, want, got));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due.size() == 0) begin
        report($sformatf("result with nothing outstanding: expected none, actual %h", got));
        return;
      end
      want = due.pop_front();
      match("pos_col", 8'(want.pos_col), 8'(got.pos_col));
      match("pos_row", 8'(want.pos_row), 8'(got.pos_row));
      match("heading", 8'(want.heading), 8'(got.heading));
      match("moved", 8'(want.moved), 8'(got.moved));
      match("reached_exit", 8'(want.reached_exit), 8'(got.reached_exit));
      match("read_wall", 8'(want.read_wall), 8'(got.read_wall));
      match("read_visited", 8'(want.read_visited), 8'(got.read_visited));
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  cfg_idx_e              cfg_idx   = CFG_GRID_COLUMNS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;

  walk_tracker sb = new();

  // Pacing knobs, in percent of cycles.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Hold-off handshake between the stimulus and the receiver process.
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  grid_wall_follower dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // Hard stop well beyond the slowest legal run, reset sweep included.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: check each result transfer, then pick the next stall value.
  // A hold request parks the channel for HOLD_CYCLES so the block backs up
  // and stalls its input while the sender keeps offering commands.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  function automatic in_item_t make_cmd(cmd_e c, int x, int y, bit w);
    in_item_t it;
    it.cmd          = c;
    it.cell_col     = COL_W'(x);
    it.cell_row     = ROW_W'(y);
    it.cell_is_wall = w;
    return it;
  endfunction

  // Start and step ignore the cell fields; fill them with noise anyway.
  function automatic in_item_t walk_cmd(cmd_e c);
    return make_cmd(c, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
  endfunction

  function automatic cfg_t make_layout(int cols, int rows, int ex, int ey, int xx, int xy);
    cfg_t c;
    c.grid_columns = LIM_W'(cols);
    c.grid_rows    = LIM_W'(rows);
    c.entry_x      = COL_W'(ex);
    c.entry_y      = ROW_W'(ey);
    c.exit_x       = COL_W'(xx);
    c.exit_y       = ROW_W'(xy);
    return c;
  endfunction

  // Offer one command and hold it until the transfer happens. Valid stays
  // high on return; the caller either offers the next command or lowers it
  // in the same time step.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    sent++;
  endtask

  // Drop valid and wait until every queued result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic put_reg(cfg_idx_e k, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= k;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  // Rewrite all registers while the block is idle.
  task automatic apply_layout(cfg_t c);
    drain();
    put_reg(CFG_GRID_COLUMNS, CFG_DATA_W'(c.grid_columns));
    put_reg(CFG_GRID_ROWS, CFG_DATA_W'(c.grid_rows));
    put_reg(CFG_ENTRY_X, CFG_DATA_W'(c.entry_x));
    put_reg(CFG_ENTRY_Y, CFG_DATA_W'(c.entry_y));
    put_reg(CFG_EXIT_X, CFG_DATA_W'(c.exit_x));
    put_reg(CFG_EXIT_Y, CFG_DATA_W'(c.exit_y));
    cfg_we  <= 1'b0;
    sb.regs = c;
  endtask

  task automatic set_pace(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 68; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 68; end
      default: begin send_idle_pct = 37; stall_pct = 37; end
    endcase
  endtask

  // Mostly small grids so walks reach the exit; now and then the full
  // store, or raw register values including zero and values past 64.
  function automatic cfg_t pick_layout();
    cfg_t c;
    int   roll;
    int   lc;
    int   lr;
    roll = $urandom_range(99);
    if (roll < 75) begin
      c.grid_columns = LIM_W'($urandom_range(2, 8));
      c.grid_rows    = LIM_W'($urandom_range(2, 8));
    end else if (roll < 85) begin
      c.grid_columns = LIM_W'(MAX_COLS);
      c.grid_rows    = LIM_W'(MAX_ROWS);
    end else begin
      c.grid_columns = LIM_W'($urandom_range(127));
      c.grid_rows    = LIM_W'($urandom_range(127));
    end
    lc = walk_tracker::span(c.grid_columns, MAX_COLS);
    lr = walk_tracker::span(c.grid_rows, MAX_ROWS);
    // Occasionally start the walker outside the grid.
    c.entry_x = COL_W'((lc == 0 || $urandom_range(9) == 0) ? $urandom_range(63)
                                                          : $urandom_range(lc - 1));
    c.entry_y = ROW_W'((lr == 0 || $urandom_range(9) == 0) ? $urandom_range(63)
                                                          : $urandom_range(lr - 1));
    c.exit_x  = COL_W'((lc == 0) ? $urandom_range(63) : $urandom_range(lc - 1));
    c.exit_y  = ROW_W'((lr == 0) ? $urandom_range(63) : $urandom_range(lr - 1));
    return c;
  endfunction

  // One random maze: load walls, start, then walk with some reads,
  // restarts and stray commands mixed in.
  task automatic run_walk_phase(int phase);
    cfg_t c;
    int   lc;
    int   lr;
    int   roll;
    c = pick_layout();
    apply_layout(c);
    set_pace(phase);
    lc = walk_tracker::span(c.grid_columns, MAX_COLS);
    lr = walk_tracker::span(c.grid_rows, MAX_ROWS);
    if (lc * lr <= 64) begin
      for (int y = 0; y < lr; y++) begin
        for (int x = 0; x < lc; x++) begin
          // Keep the entry cell open.
          send_item(make_cmd(CMD_LOAD, x, y,
            (x == int'(c.entry_x) && y == int'(c.entry_y)) ? 1'b0
                                                           : ($urandom_range(99) < 30)));
        end
      end
    end else begin
      repeat (24) send_item(make_cmd(CMD_LOAD, $urandom_range(lc - 1),
                                     $urandom_range(lr - 1), $urandom_range(99) < 30));
    end
    send_item(walk_cmd(CMD_START));
    // First random phase runs flat out: park the receiver and let it back up.
    if (phase == 0) hold_req++;
    repeat ($urandom_range(12, 40)) begin
      roll = $urandom_range(99);
      if (roll < 82) begin
        send_item(walk_cmd(CMD_STEP));
      end else if (roll < 88) begin
        send_item(make_cmd(CMD_READ, (lc == 0) ? $urandom_range(63) : $urandom_range(lc - 1),
                           (lr == 0) ? $urandom_range(63) : $urandom_range(lr - 1), 1'b0));
      end else if (roll < 94) begin
        send_item(make_cmd(cmd_e'(2'($urandom_range(3))), $urandom_range(63),
                           $urandom_range(63), 1'($urandom_range(1))));
      end else begin
        send_item(walk_cmd(CMD_START));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int phase;
    phase = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: 64 x 64 grid, entry and exit at the origin. The input
    // stays stalled through the memory clearing sweep.
    send_item(make_cmd(CMD_READ, 0, 0, 1'b0));
    send_item(make_cmd(CMD_LOAD, 63, 63, 1'b1));
    send_item(make_cmd(CMD_READ, 63, 63, 1'b0));
    send_item(make_cmd(CMD_LOAD, 0, 1, 1'b1));      // block south of the origin
    send_item(walk_cmd(CMD_STEP));                   // south walled: go east
    send_item(make_cmd(CMD_READ, 1, 0, 1'b0));      // visited now set
    send_item(make_cmd(CMD_LOAD, 1, 0, 1'b0));      // load clears visited
    send_item(make_cmd(CMD_READ, 1, 0, 1'b0));
    send_item(walk_cmd(CMD_STEP));
    send_item(make_cmd(CMD_LOAD, 63, 0, 1'b0));
    send_item(make_cmd(CMD_LOAD, 42, 21, 1'b1));
    send_item(make_cmd(CMD_READ, 42, 21, 1'b0));
    send_item(make_cmd(CMD_READ, 21, 42, 1'b0));
    send_item(walk_cmd(CMD_START));                  // back to the origin, no exit test
    send_item(walk_cmd(CMD_STEP));
    send_item(walk_cmd(CMD_STEP));
    send_item(walk_cmd(CMD_STEP));

    // Single-cell grid: boxed in, turn west, finish on the spot.
    apply_layout(make_layout(1, 1, 0, 0, 0, 0));
    send_item(walk_cmd(CMD_START));
    send_item(walk_cmd(CMD_STEP));
    send_item(walk_cmd(CMD_STEP));

    // Zero-size grid: every neighbor is outside.
    apply_layout(make_layout(0, 0, 0, 0, 5, 5));
    send_item(walk_cmd(CMD_START));
    send_item(walk_cmd(CMD_STEP));

    // Entry just outside a 3 x 3 grid: only the west neighbor is inside.
    apply_layout(make_layout(3, 3, 3, 1, 2, 1));
    send_item(walk_cmd(CMD_START));
    send_item(walk_cmd(CMD_STEP));
    send_item(walk_cmd(CMD_STEP));

    // Oversized registers clip to the store; walk up the east edge from the
    // far corner to an exit in the top row and past it.
    apply_layout(make_layout(127, 127, 63, 63, 63, 0));
    send_item(walk_cmd(CMD_START));
    repeat (66) send_item(walk_cmd(CMD_STEP));
    send_item(make_cmd(CMD_READ, 63, 31, 1'b0));

    while (sent < ITEM_TARGET) begin
      run_walk_phase(phase);
      phase++;
    end

    // Let the last results drain, then allow a few spare cycles for strays.
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/gwf_pkg.sv
rtl/core/gwf_cell_mem.sv
rtl/core/gwf_walker.sv
rtl/core/grid_wall_follower.sv
sim/tb_grid_wall_follower.sv
